>>> hdl/pca_pkg.sv
package pca_pkg;

    localparam int COORD_W     = 16;
    localparam int COUNT_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int TURN_W      = PROD_W + 1;
    localparam int EDGE_PW     = 2 * COORD_W;
    localparam int EDGE_W      = EDGE_PW + 1;
    localparam int AREA_W      = 48;
    localparam int MAG_W       = 47;
    localparam int SUM_W       = AREA_W + 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + MAG_W + COUNT_W + 1);

    localparam logic [COUNT_W-1:0]       COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0]       MIN_VERTICES = COUNT_W'(3);
    localparam logic signed [SUM_W-1:0]  AREA_MAX     = SUM_W'({1'b0, {MAG_W{1'b1}}});
    localparam logic signed [SUM_W-1:0]  AREA_MIN     = -AREA_MAX;

    // Turn sign flags: bit 0 marks a clockwise turn, bit 1 an anticlockwise one.
    localparam logic [1:0] TURN_NONE = 2'b00;
    localparam logic [1:0] TURN_NEG  = 2'b01;
    localparam logic [1:0] TURN_POS  = 2'b10;

    // Products registered after the front stage.
    typedef struct packed {
        logic signed [PROD_W-1:0]  tn_ad;
        logic signed [PROD_W-1:0]  tn_bc;
        logic signed [PROD_W-1:0]  tc_ad;
        logic signed [PROD_W-1:0]  tc_bc;
        logic signed [PROD_W-1:0]  tw_ad;
        logic signed [PROD_W-1:0]  tw_bc;
        logic signed [EDGE_PW-1:0] en_a;
        logic signed [EDGE_PW-1:0] en_b;
        logic signed [EDGE_PW-1:0] ec_a;
        logic signed [EDGE_PW-1:0] ec_b;
        logic                      turn_en;
        logic                      close_turn;
        logic                      edge_en;
        logic                      close_edge;
        logic                      last;
        logic                      cnt_sat;
        logic [COUNT_W-1:0]        count;
    } prod_t;

    // Turn signs and edge terms registered after the cross stage.
    typedef struct packed {
        logic [1:0]               signs;
        logic signed [EDGE_W-1:0] edge_term;
        logic signed [EDGE_W-1:0] close_term;
        logic                     last;
        logic                     cnt_sat;
        logic [COUNT_W-1:0]       count;
    } term_t;

    // Polygon summary handed from the accumulator to the output stage.
    typedef struct packed {
        logic signed [AREA_W-1:0] area;
        logic signed [EDGE_W-1:0] close_term;
        logic                     sat;
        logic                     convex;
        logic [COUNT_W-1:0]       count;
    } poly_t;

    typedef struct packed {
        logic signed [AREA_W-1:0] area;
        logic                     clamped;
    } sat_sum_t;

    function automatic logic [1:0] turn_sign(input logic signed [TURN_W-1:0] t);
        logic [1:0] s;
        if (t < 0)
            s = TURN_NEG;
        else if (t != 0)
            s = TURN_POS;
        else
            s = TURN_NONE;
        return s;
    endfunction

    // Adds an edge term to the running area and clamps it to the symmetric range.
    function automatic sat_sum_t sat_add(input logic signed [AREA_W-1:0] a,
                                         input logic signed [EDGE_W-1:0] t);
        logic signed [SUM_W-1:0] s;
        sat_sum_t r;
        s = SUM_W'(a) + SUM_W'(t);
        if (s > AREA_MAX)
        begin
            r.area    = AREA_W'(AREA_MAX);
            r.clamped = 1'b1;
        end
        else if (s < AREA_MIN)
        begin
            r.area    = AREA_W'(AREA_MIN);
            r.clamped = 1'b1;
        end
        else
        begin
            r.area    = AREA_W'(s);
            r.clamped = 1'b0;
        end
        return r;
    endfunction

endpackage

>>> hdl/pca_front.sv
module pca_front
    import pca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  accept,
    input  logic [IN_TDATA_W-1:0] in_data,
    input  logic                  in_last,
    output logic                  prod_valid,
    output prod_t                 prod
);

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, second_x_reg, second_y_reg;
    logic signed [COORD_W-1:0] prior_x_reg, prior_y_reg, bp_x_reg, bp_y_reg;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      valid_reg;
    prod_t                     prod_reg, prod_next;

    logic signed [COORD_W-1:0] vx, vy;
    logic signed [DIFF_W-1:0]  pbx, pby, vpx, vpy, fvx, fvy, sfx, sfy;
    logic                      cnt_sat;

    function automatic logic signed [DIFF_W-1:0] diff(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    always_comb
    begin
        vx  = signed'(in_data[COORD_W-1:0]);
        vy  = signed'(in_data[2*COORD_W-1:COORD_W]);
        pbx = diff(prior_x_reg, bp_x_reg);
        pby = diff(prior_y_reg, bp_y_reg);
        vpx = diff(vx, prior_x_reg);
        vpy = diff(vy, prior_y_reg);
        fvx = diff(first_x_reg, vx);
        fvy = diff(first_y_reg, vy);
        sfx = diff(second_x_reg, first_x_reg);
        sfy = diff(second_y_reg, first_y_reg);

        cnt_sat    = (count_reg == COUNT_MAX);
        count_next = cnt_sat ? count_reg : count_reg + COUNT_W'(1);

        prod_next.tn_ad      = PROD_W'(pbx) * PROD_W'(vpy);
        prod_next.tn_bc      = PROD_W'(pby) * PROD_W'(vpx);
        prod_next.tc_ad      = PROD_W'(vpx) * PROD_W'(fvy);
        prod_next.tc_bc      = PROD_W'(vpy) * PROD_W'(fvx);
        prod_next.tw_ad      = PROD_W'(fvx) * PROD_W'(sfy);
        prod_next.tw_bc      = PROD_W'(fvy) * PROD_W'(sfx);
        prod_next.en_a       = EDGE_PW'(prior_x_reg) * EDGE_PW'(vy);
        prod_next.en_b       = EDGE_PW'(vx) * EDGE_PW'(prior_y_reg);
        prod_next.ec_a       = EDGE_PW'(vx) * EDGE_PW'(first_y_reg);
        prod_next.ec_b       = EDGE_PW'(first_x_reg) * EDGE_PW'(vy);
        prod_next.turn_en    = (count_reg >= COUNT_W'(2));
        prod_next.edge_en    = (count_reg != '0);
        prod_next.close_turn = in_last && (count_next >= MIN_VERTICES);
        prod_next.close_edge = in_last && (count_next >= COUNT_W'(2));
        prod_next.last       = in_last;
        prod_next.cnt_sat    = cnt_sat;
        prod_next.count      = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                valid_reg <= accept;
            if (accept)
                count_reg <= in_last ? '0 : count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg    <= prod_next;
            bp_x_reg    <= prior_x_reg;
            bp_y_reg    <= prior_y_reg;
            prior_x_reg <= vx;
            prior_y_reg <= vy;
            if (count_reg == '0)
            begin
                first_x_reg <= vx;
                first_y_reg <= vy;
            end
            if (count_reg == COUNT_W'(1))
            begin
                second_x_reg <= vx;
                second_y_reg <= vy;
            end
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

>>> hdl/pca_cross.sv
module pca_cross
    import pca_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  prod_valid,
    input  prod_t prod,
    output logic  term_valid,
    output term_t term
);

    logic  valid_reg;
    term_t term_reg, term_next;
    logic signed [TURN_W-1:0] tn, tc, tw;
    logic [1:0]               s_run, s_close;

    always_comb
    begin
        tn      = TURN_W'(prod.tn_ad) - TURN_W'(prod.tn_bc);
        tc      = TURN_W'(prod.tc_ad) - TURN_W'(prod.tc_bc);
        tw      = TURN_W'(prod.tw_ad) - TURN_W'(prod.tw_bc);
        s_run   = prod.turn_en ? turn_sign(tn) : TURN_NONE;
        s_close = prod.close_turn ? (turn_sign(tc) | turn_sign(tw)) : TURN_NONE;

        term_next.signs      = s_run | s_close;
        term_next.edge_term  = prod.edge_en
                             ? EDGE_W'(prod.en_a) - EDGE_W'(prod.en_b) : '0;
        term_next.close_term = prod.close_edge
                             ? EDGE_W'(prod.ec_a) - EDGE_W'(prod.ec_b) : '0;
        term_next.last       = prod.last;
        term_next.cnt_sat    = prod.cnt_sat;
        term_next.count      = prod.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= prod_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            term_reg <= term_next;
    end

    assign term_valid = valid_reg;
    assign term       = term_reg;

endmodule

>>> hdl/pca_accum.sv
module pca_accum
    import pca_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  term_valid,
    input  term_t term,
    output logic  poly_valid,
    output poly_t poly
);

    logic signed [AREA_W-1:0] area_reg;
    logic [1:0]               signs_reg;
    logic                     sat_reg;
    logic                     valid_reg;
    poly_t                    poly_reg, poly_next;
    sat_sum_t                 sum;
    logic [1:0]               signs_all;
    logic                     sat_all;

    always_comb
    begin
        sum       = sat_add(area_reg, term.edge_term);
        signs_all = signs_reg | term.signs;
        sat_all   = sat_reg | term.cnt_sat | sum.clamped;

        poly_next.area       = sum.area;
        poly_next.close_term = term.close_term;
        poly_next.sat        = sat_all;
        poly_next.convex     = (term.count >= MIN_VERTICES)
                            && (signs_all == TURN_NEG || signs_all == TURN_POS);
        poly_next.count      = term.count;
    end

    // The running sums restart as soon as the closing vertex passes this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg  <= '0;
            signs_reg <= TURN_NONE;
            sat_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= term_valid && term.last;
            if (term_valid)
            begin
                if (term.last)
                begin
                    area_reg  <= '0;
                    signs_reg <= TURN_NONE;
                    sat_reg   <= 1'b0;
                end
                else
                begin
                    area_reg  <= sum.area;
                    signs_reg <= signs_all;
                    sat_reg   <= sat_all;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && term_valid && term.last)
            poly_reg <= poly_next;
    end

    assign poly_valid = valid_reg;
    assign poly       = poly_reg;

endmodule

>>> hdl/pca_finish.sv
module pca_finish
    import pca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   poly_valid,
    input  poly_t                  poly,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    sat_sum_t               sum;
    logic signed [AREA_W-1:0] mag;
    logic                   sat;

    always_comb
    begin
        sum = sat_add(poly.area, poly.close_term);
        sat = poly.sat | sum.clamped;
        // The clamped sum lies within the symmetric range, so its negation fits.
        mag = (sum.area < 0) ? -sum.area : sum.area;
        data_next = {OUT_PAD_W'(0), sat, poly.count, mag[MAG_W-1:0], poly.convex};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv && poly_valid)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && poly_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/polygon_convexity_area_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata: vertex_x, vertex_y; tlast: last_vertex
// m_axis    out        tdata: is_convex, twice_area, vertex_total, overflow
//
// One vertex is taken in every cycle while input transfers are not stalled.
// The pipeline runs through a product stage, a cross stage, the area accumulator
// and the output register, and a result passes them in that order.
// Reset clears the vertex count, the running sums and all valid flags.
// Input transfers stall only while an unread result sits in the output register
// and the next result has already reached the accumulator stage.
module polygon_convexity_area_top
    import pca_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] vertex_x, [31:16] vertex_y
    input  logic                   s_axis_tlast,   // last_vertex
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [0] is_convex, [47:1] twice_area,
                                                   // [63:48] vertex_total, [64] overflow
);

    logic  adv;
    logic  accept;
    logic  prod_valid, term_valid, poly_valid;
    prod_t prod;
    term_t term;
    poly_t poly;

    assign adv           = !(m_axis_tvalid && !m_axis_tready && poly_valid);
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;

    pca_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .accept     (accept),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    pca_cross u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .prod_valid (prod_valid),
        .prod       (prod),
        .term_valid (term_valid),
        .term       (term)
    );

    pca_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .term_valid (term_valid),
        .term       (term),
        .poly_valid (poly_valid),
        .poly       (poly)
    );

    pca_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .poly_valid (poly_valid),
        .poly       (poly),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata)
    );

endmodule

>>> verif/tb_polygon_convexity_area_top.sv
module tb_polygon_convexity_area_top;
    import pca_pkg::*;

    localparam longint AREA_LIMIT  = (longint'(1) << MAG_W) - 1;
    localparam int     CYCLE_LIMIT = 100_000;
    localparam int     MAX_REPORTS = 10;
    localparam int     RANDOM_ITEMS = 1700;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        bit                        drain;
    } vertex_item_t;

    typedef struct {
        logic               convex;
        logic [MAG_W-1:0]   area;
        logic [COUNT_W-1:0] total;
        logic               overflow;
    } shape_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    vertex_item_t  pending_vertices[$];
    shape_result_t expected_shapes[$];

    // Shadow of the block's polygon state.
    longint             first_x, first_y, second_x, second_y;
    longint             prior_x, prior_y, older_x, older_y;
    logic [COUNT_W-1:0] seen;
    logic [1:0]         turn_mask;
    longint             area_sum;
    logic               clipped;

    vertex_item_t on_bus;
    int tx_gap = 0;
    int tx_steady = 0;
    int rx_gap = 0;
    int rx_steady = 0;
    int gap;
    int cycles = 0;
    int fault_count = 0;
    int vertices_sent = 0;
    int shapes_checked = 0;
    int convex_seen = 0;
    int overflow_seen = 0;

    polygon_convexity_area_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Idle cycles before the next transfer; now and then a stretch runs with none.
    function automatic int draw_pause(inout int steady);
        if (steady > 0)
        begin
            steady--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
        begin
            steady = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic clear_polygon();
        first_x = 0; first_y = 0; second_x = 0; second_y = 0;
        prior_x = 0; prior_y = 0; older_x = 0; older_y = 0;
        seen = '0;
        turn_mask = TURN_NONE;
        area_sum = 0;
        clipped = 1'b0;
    endtask

    task automatic record_turn(input longint ax, ay, bx, by, cx, cy);
        longint t;
        t = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
        if (t < 0)
            turn_mask |= TURN_NEG;
        else if (t != 0)
            turn_mask |= TURN_POS;
    endtask

    // The running doubled area is clamped to the symmetric range after every edge.
    task automatic add_shoelace_term(input longint px, py, qx, qy);
        longint s;
        s = area_sum + px * qy - qx * py;
        if (s > AREA_LIMIT)
        begin
            area_sum = AREA_LIMIT;
            clipped = 1'b1;
        end
        else if (s < -AREA_LIMIT)
        begin
            area_sum = -AREA_LIMIT;
            clipped = 1'b1;
        end
        else
            area_sum = s;
    endtask

    task automatic trace_vertex(input vertex_item_t v);
        longint vx, vy;
        shape_result_t r;
        vx = v.x;
        vy = v.y;
        if (seen >= 2)
            record_turn(older_x, older_y, prior_x, prior_y, vx, vy);
        if (seen >= 1)
            add_shoelace_term(prior_x, prior_y, vx, vy);
        if (seen == 0)
        begin
            first_x = vx;
            first_y = vy;
        end
        if (seen == 1)
        begin
            second_x = vx;
            second_y = vy;
        end
        older_x = prior_x;
        older_y = prior_y;
        prior_x = vx;
        prior_y = vy;
        if (seen == COUNT_MAX)
            clipped = 1'b1;
        else
            seen++;
        if (v.last)
        begin
            // Close the polygon: two wrap-around turns and the closing edge.
            if (seen >= MIN_VERTICES)
            begin
                record_turn(older_x, older_y, vx, vy, first_x, first_y);
                record_turn(vx, vy, first_x, first_y, second_x, second_y);
            end
            if (seen >= 2)
                add_shoelace_term(vx, vy, first_x, first_y);
            r.convex   = (seen >= MIN_VERTICES) && (turn_mask != TURN_NONE)
                         && (turn_mask != (TURN_NEG | TURN_POS));
            r.area     = MAG_W'(area_sum < 0 ? -area_sum : area_sum);
            r.total    = seen;
            r.overflow = clipped;
            expected_shapes = {expected_shapes, r};
            clear_polygon();
        end
    endtask

    task automatic push_vertex(input int x, input int y, input bit last, input bit drain);
        vertex_item_t v;
        v.x = COORD_W'(x);
        v.y = COORD_W'(y);
        v.last = last;
        v.drain = drain;
        pending_vertices = {pending_vertices, v};
    endtask

    // Sender: the next vertex is presented once its idle cycles have passed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            tx_gap        <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                trace_vertex(on_bus);
                vertices_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                gap = s_axis_tvalid ? draw_pause(tx_steady) : tx_gap;
                if (gap > 0)
                begin
                    tx_gap        <= gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_vertices.size() != 0 &&
                         !(pending_vertices[0].drain && expected_shapes.size() != 0))
                begin
                    on_bus = pending_vertices.pop_front();
                    s_axis_tdata  <= {on_bus.y, on_bus.x};
                    s_axis_tlast  <= on_bus.last;
                    s_axis_tvalid <= 1'b1;
                    tx_gap        <= 0;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap        <= 0;
                end
            end
        end
    end

    // Receiver: checks each result transfer against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        shape_result_t want, got;
        int pause;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_gap        <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.convex   = m_axis_tdata[0];
                got.area     = m_axis_tdata[MAG_W:1];
                got.total    = m_axis_tdata[MAG_W+COUNT_W:MAG_W+1];
                got.overflow = m_axis_tdata[MAG_W+COUNT_W+1];
                if (expected_shapes.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("Unexpected result: convex=%0b area=%0d total=%0d overflow=%0b",
                                 got.convex, got.area, got.total, got.overflow);
                end
                else
                begin
                    want = expected_shapes.pop_front();
                    shapes_checked++;
                    if (want.convex)
                        convex_seen++;
                    if (want.overflow)
                        overflow_seen++;
                    if (got.convex !== want.convex || got.area !== want.area ||
                        got.total !== want.total || got.overflow !== want.overflow)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                        begin
                            $display("Polygon %0d mismatch", shapes_checked);
                            $display("  expected convex=%0b area=%0d total=%0d overflow=%0b",
                                     want.convex, want.area, want.total, want.overflow);
                            $display("  actual   convex=%0b area=%0d total=%0d overflow=%0b",
                                     got.convex, got.area, got.total, got.overflow);
                        end
                    end
                end
                pause = draw_pause(rx_steady);
                rx_gap        <= pause;
                m_axis_tready <= (pause == 0);
            end
            else if (rx_gap > 0)
            begin
                rx_gap        <= rx_gap - 1;
                m_axis_tready <= (rx_gap == 1);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int random_items;
        int kind, len, cx, cy, r, a, rot, emitted, idx;
        bit rev, drain;
        logic [7:0] pick;
        int ox[8];
        int oy[8];
        int extremes[4];

        clear_polygon();
        extremes = '{-32768, -1, 0, 32767};

        // Directed shapes: single vertex, two vertices, collinear points,
        // extreme-corner triangle and square, a concave pentagon and a repeated vertex.
        push_vertex(32767, -32768, 1, 0);
        push_vertex(-32768, 32767, 0, 0);
        push_vertex(32767, -32768, 1, 0);
        push_vertex(0, 0, 0, 0);
        push_vertex(5, 5, 0, 0);
        push_vertex(10, 10, 1, 0);
        push_vertex(-32768, -32768, 0, 0);
        push_vertex(32767, -32768, 0, 0);
        push_vertex(32767, 32767, 1, 0);
        push_vertex(-32768, -32768, 0, 0);
        push_vertex(-32768, 32767, 0, 0);
        push_vertex(32767, 32767, 0, 0);
        push_vertex(32767, -32768, 1, 0);
        push_vertex(0, 0, 0, 0);
        push_vertex(10, 0, 0, 0);
        push_vertex(5, 2, 0, 0);
        push_vertex(10, 10, 0, 0);
        push_vertex(0, 10, 1, 0);
        push_vertex(0, 0, 0, 0);
        push_vertex(0, 0, 0, 0);
        push_vertex(4, 0, 0, 0);
        push_vertex(0, 4, 1, 0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            kind  = $urandom_range(0, 99);
            drain = (random_items == 0) || ($urandom_range(0, 39) == 0);
            if (kind < 40)
            begin
                // Convex: an ordered subset of a strictly convex octagon.
                r  = $urandom_range(10, 12000);
                a  = r * 7 / 10;
                cx = int'($urandom_range(0, 40000)) - 20000;
                cy = int'($urandom_range(0, 40000)) - 20000;
                ox = '{r, a, 0, -a, -r, -a, 0, a};
                oy = '{0, a, r, a, 0, -a, -r, -a};
                pick = $urandom_range(1, 255);
                if ($countones(pick) < 3)
                    pick |= 8'b0010_0101;
                len = $countones(pick);
                rot = $urandom_range(0, 7);
                rev = $urandom_range(0, 1);
                emitted = 0;
                for (int k = 0; k < 8; k++)
                begin
                    idx = rev ? (rot + 8 - k) % 8 : (rot + k) % 8;
                    if (pick[idx])
                    begin
                        push_vertex(cx + ox[idx], cy + oy[idx], emitted == len - 1,
                                    drain && emitted == 0);
                        emitted++;
                    end
                end
            end
            else
            begin
                len = (kind < 65) ? $urandom_range(1, 10) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    if (kind < 65)
                        push_vertex($urandom, $urandom, i == len - 1, drain && i == 0);
                    else if (kind < 90)
                        push_vertex(int'($urandom_range(0, 16)) - 8,
                                    int'($urandom_range(0, 16)) - 8,
                                    i == len - 1, drain && i == 0);
                    else
                        push_vertex(extremes[$urandom_range(0, 3)],
                                    extremes[$urandom_range(0, 3)],
                                    i == len - 1, drain && i == 0);
                end
            end
            random_items += len;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_vertices.size() != 0 || s_axis_tvalid || expected_shapes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d polygons built from %0d vertices: %0d convex, %0d saturated.",
                 shapes_checked, vertices_sent, convex_seen, overflow_seen);
        $display("Mismatches: %0d", fault_count);
        if (fault_count == 0 && expected_shapes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> polygon_convexity_area_top.f
hdl/pca_pkg.sv
hdl/pca_front.sv
hdl/pca_cross.sv
hdl/pca_accum.sv
hdl/pca_finish.sv
hdl/polygon_convexity_area_top.sv
verif/tb_polygon_convexity_area_top.sv
